// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfs assertion failed");

// next-cycle implication
`define SFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfs assertion failed");

`endif

// File: rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// types, constants and helpers of the sync frame and text line splitter
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

  localparam int WINDOW_BYTES = 32;
  localparam int LINE_BYTES   = 128;

  localparam int WIN_AW = $clog2(WINDOW_BYTES);
  localparam int CNT_W  = $clog2(WINDOW_BYTES + 1);
  localparam int LINE_W = $clog2(LINE_BYTES);
  // frame total from an 8-bit length plus overhead
  localparam int TOT_W  = 9;

  localparam logic [7:0] SYNC_A  = 8'hAA;
  localparam logic [7:0] SYNC_B  = 8'h55;
  localparam logic [7:0] PAY_P0  = 8'h00;
  localparam logic [7:0] PAY_P1  = 8'hFF;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;

  localparam int HEAD_BYTES     = 4;
  localparam int FRAME_OVERHEAD = 5;
  localparam int IDX_SYNC_B     = 1;
  localparam int IDX_CMD        = 2;
  localparam int IDX_LEN        = 3;
  localparam int IDX_P0         = 4;
  localparam int IDX_P1         = 5;
  localparam int TRIG_TOTAL     = 7;

  // register map
  localparam logic REG_START_CMD = 1'b0;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_LINE_END = 2'd1,
    KIND_OVERFLOW = 2'd2,
    KIND_TRIGGER  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_B0,
    ST_B1,
    ST_LEN,
    ST_SUM,
    ST_FRAME,
    ST_RELEASE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic emit;
    res_t res;
  } txt_t;

  typedef struct packed {
    logic push;
    logic flush;
    res_t res;
  } push_t;

  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } push_ack_t;

  // circular window index: base plus offset, folded once
  function automatic logic [WIN_AW-1:0] win_idx(input logic [WIN_AW-1:0] base,
                                                input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(WINDOW_BYTES)) begin
      s = s - (CNT_W+1)'(WINDOW_BYTES);
    end
    return s[WIN_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/sfs_ram.sv
// ----------------------------------------------------------------------------
// sfs_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/sfs_text.sv
// ----------------------------------------------------------------------------
// sfs_text
// log line builder for released bytes, holds the pending line length
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_text (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [7:0]   ch,
  input  wire logic         commit,
  output sfs_pkg::txt_t     txt
);

  logic [sfs_pkg::LINE_W-1:0] line_len;
  logic [sfs_pkg::LINE_W-1:0] line_len_next;

  always_comb begin
    txt           = '0;
    line_len_next = line_len;
    if (ch == sfs_pkg::CH_LF) begin
      txt.emit       = (line_len != '0);
      txt.res.kind   = sfs_pkg::KIND_LINE_END;
      line_len_next  = '0;
    end else if (ch == sfs_pkg::CH_CR) begin
      txt.emit = 1'b0;
    end else if (line_len < sfs_pkg::LINE_W'(sfs_pkg::LINE_BYTES - 1)) begin
      txt.emit      = 1'b1;
      txt.res.kind  = sfs_pkg::KIND_CHAR;
      txt.res.data  = ch;
      line_len_next = line_len + 1'b1;
    end else begin
      // line full, cut it and drop this char
      txt.emit      = 1'b1;
      txt.res.kind  = sfs_pkg::KIND_OVERFLOW;
      line_len_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_len <= '0;
    end else if (commit) begin
      line_len <= line_len_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sfs_outbuf.sv
// ----------------------------------------------------------------------------
// sfs_outbuf
// holds the newest result back one step so the final one can carry last
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sfs_outbuf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sfs_pkg::push_t req,
  output sfs_pkg::push_ack_t  ack,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [1:0]          kind,
  output logic [7:0]          data_byte,
  output logic                last
);

  logic          held_valid;
  sfs_pkg::res_t held_res;
  logic          out_free;

  assign out_free     = !out_valid || !out_stall;
  assign ack.push_ok  = !held_valid || out_free;
  assign ack.flush_ok = !held_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (req.push && ack.push_ok) begin
        if (held_valid) begin
          out_valid <= 1'b1;
        end else if (out_valid && !out_stall) begin
          out_valid <= 1'b0;
        end
        held_valid <= 1'b1;
      end else if (req.flush && ack.flush_ok && held_valid) begin
        out_valid  <= 1'b1;
        held_valid <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (req.push && ack.push_ok) begin
      if (held_valid) begin
        kind      <= held_res.kind;
        data_byte <= held_res.data;
        last      <= 1'b0;
      end
      held_res <= req.res;
    end else if (req.flush && ack.flush_ok && held_valid) begin
      kind      <= held_res.kind;
      data_byte <= held_res.data;
      last      <= 1'b1;
    end
  end

  `SFS_ASSERT_NEXT(a_flush_marks_last, clk, rst,
                   req.flush && ack.flush_ok && held_valid, out_valid && last)

endmodule

`default_nettype wire

// File: rtl/sfs_scan.sv
// ----------------------------------------------------------------------------
// sfs_scan
// window sequencer: stores bytes, checks header and checksum, releases text
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sfs_scan (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [7:0]         start_cmd,
  input  wire sfs_pkg::push_ack_t ack,
  output sfs_pkg::push_t          req,
  output logic [7:0]              txt_ch,
  output logic                    txt_commit,
  input  wire sfs_pkg::txt_t      txt
);

  sfs_pkg::state_t state, state_next;

  logic [sfs_pkg::WIN_AW-1:0] head, head_next;
  logic [sfs_pkg::CNT_W-1:0]  fill, fill_next;
  logic [sfs_pkg::CNT_W-1:0]  total, total_next;
  logic [sfs_pkg::CNT_W-1:0]  idx, idx_next;
  logic [7:0]                 sum, sum_next;
  logic [7:0]                 b0, b0_next;
  logic                       cmd_ok, cmd_ok_next;
  logic                       p0_ok, p0_ok_next;
  logic                       p1_ok, p1_ok_next;

  logic [sfs_pkg::CNT_W-1:0]  rd_off;
  logic                       we;
  logic [7:0]                 rdata;
  logic [sfs_pkg::TOT_W-1:0]  tot;
  logic                       trig;

  sfs_ram #(.WIDTH(8), .DEPTH(sfs_pkg::WINDOW_BYTES)) u_window (
    .clk   (clk),
    .we    (we),
    .waddr (sfs_pkg::win_idx(head, fill)),
    .wdata (rx_byte),
    .raddr (sfs_pkg::win_idx(head, rd_off)),
    .rdata (rdata)
  );

  assign in_stall = (state != sfs_pkg::ST_IDLE);
  assign txt_ch   = b0;
  assign tot      = sfs_pkg::TOT_W'(rdata) + sfs_pkg::TOT_W'(sfs_pkg::FRAME_OVERHEAD);
  assign trig     = cmd_ok && p0_ok && p1_ok &&
                    (total == sfs_pkg::CNT_W'(sfs_pkg::TRIG_TOTAL));

  always_comb begin
    state_next  = state;
    head_next   = head;
    fill_next   = fill;
    total_next  = total;
    idx_next    = idx;
    sum_next    = sum;
    b0_next     = b0;
    cmd_ok_next = cmd_ok;
    p0_ok_next  = p0_ok;
    p1_ok_next  = p1_ok;
    rd_off      = '0;
    we          = 1'b0;
    txt_commit  = 1'b0;
    req         = '0;

    case (state)
      sfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          we         = 1'b1;
          fill_next  = fill + 1'b1;
          state_next = sfs_pkg::ST_CHECK;
        end
      end
      sfs_pkg::ST_CHECK: begin
        if (fill == '0) begin
          state_next = sfs_pkg::ST_FINISH;
        end else begin
          state_next = sfs_pkg::ST_B0;
        end
      end
      sfs_pkg::ST_B0: begin
        b0_next = rdata;
        if (rdata != sfs_pkg::SYNC_A) begin
          state_next = sfs_pkg::ST_RELEASE;
        end else if (fill < sfs_pkg::CNT_W'(sfs_pkg::IDX_SYNC_B + 1)) begin
          state_next = sfs_pkg::ST_FINISH;
        end else begin
          rd_off     = sfs_pkg::CNT_W'(sfs_pkg::IDX_SYNC_B);
          state_next = sfs_pkg::ST_B1;
        end
      end
      sfs_pkg::ST_B1: begin
        if (rdata != sfs_pkg::SYNC_B) begin
          state_next = sfs_pkg::ST_RELEASE;
        end else if (fill < sfs_pkg::CNT_W'(sfs_pkg::HEAD_BYTES)) begin
          state_next = sfs_pkg::ST_FINISH;
        end else begin
          rd_off     = sfs_pkg::CNT_W'(sfs_pkg::IDX_LEN);
          state_next = sfs_pkg::ST_LEN;
        end
      end
      sfs_pkg::ST_LEN: begin
        if (tot > sfs_pkg::TOT_W'(sfs_pkg::WINDOW_BYTES)) begin
          state_next = sfs_pkg::ST_RELEASE;
        end else if (sfs_pkg::TOT_W'(fill) < tot) begin
          state_next = sfs_pkg::ST_FINISH;
        end else begin
          total_next  = tot[sfs_pkg::CNT_W-1:0];
          idx_next    = '0;
          sum_next    = '0;
          cmd_ok_next = 1'b0;
          p0_ok_next  = 1'b0;
          p1_ok_next  = 1'b0;
          rd_off      = '0;
          state_next  = sfs_pkg::ST_SUM;
        end
      end
      sfs_pkg::ST_SUM: begin
        if (idx == total - 1'b1) begin
          if (sum == rdata) begin
            state_next = sfs_pkg::ST_FRAME;
          end else begin
            state_next = sfs_pkg::ST_RELEASE;
          end
        end else begin
          sum_next = sum + rdata;
          if (idx == sfs_pkg::CNT_W'(sfs_pkg::IDX_CMD)) begin
            cmd_ok_next = (rdata == start_cmd);
          end
          if (idx == sfs_pkg::CNT_W'(sfs_pkg::IDX_P0)) begin
            p0_ok_next = (rdata == sfs_pkg::PAY_P0);
          end
          if (idx == sfs_pkg::CNT_W'(sfs_pkg::IDX_P1)) begin
            p1_ok_next = (rdata == sfs_pkg::PAY_P1);
          end
          idx_next = idx + 1'b1;
          rd_off   = idx + 1'b1;
        end
      end
      sfs_pkg::ST_FRAME: begin
        if (!trig || ack.push_ok) begin
          req.push     = trig;
          req.res.kind = sfs_pkg::KIND_TRIGGER;
          head_next    = sfs_pkg::win_idx(head, total);
          fill_next    = fill - total;
          state_next   = sfs_pkg::ST_CHECK;
        end
      end
      sfs_pkg::ST_RELEASE: begin
        if (!txt.emit || ack.push_ok) begin
          txt_commit = 1'b1;
          req.push   = txt.emit;
          req.res    = txt.res;
          head_next  = sfs_pkg::win_idx(head, sfs_pkg::CNT_W'(1));
          fill_next  = fill - 1'b1;
          state_next = sfs_pkg::ST_CHECK;
        end
      end
      sfs_pkg::ST_FINISH: begin
        req.flush = 1'b1;
        if (ack.flush_ok) begin
          state_next = sfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfs_pkg::ST_IDLE;
      head  <= '0;
      fill  <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    total  <= total_next;
    idx    <= idx_next;
    sum    <= sum_next;
    b0     <= b0_next;
    cmd_ok <= cmd_ok_next;
    p0_ok  <= p0_ok_next;
    p1_ok  <= p1_ok_next;
  end

  `SFS_ASSERT_IMPL(a_idle_fill_below_window, clk, rst,
                   state == sfs_pkg::ST_IDLE, fill < sfs_pkg::CNT_W'(sfs_pkg::WINDOW_BYTES))
  `SFS_ASSERT_IMPL(a_sum_index_in_frame, clk, rst,
                   state == sfs_pkg::ST_SUM, idx < total && total <= fill)
  `SFS_ASSERT_NEXT(a_accept_starts_scan, clk, rst,
                   state == sfs_pkg::ST_IDLE && in_valid, state == sfs_pkg::ST_CHECK)

endmodule

`default_nettype wire

// File: rtl/sync_frame_and_text_line_splitter_unit.sv
// ----------------------------------------------------------------------------
// sync_frame_and_text_line_splitter_unit
// splits a received byte stream into silent sync frames and log text lines
// ----------------------------------------------------------------------------
// input: rx_byte with in_valid, the block drives in_stall; a request is taken
//   when in_valid is high and in_stall low, and in_stall stays high from the
//   accept until the window scan for that byte has flushed its results
// output: kind, data_byte and last with out_valid, the receiver drives
//   out_stall; last marks the final result of one request, a request that
//   causes nothing gives no result at all
// scan steps per window start, after the accept: an empty check, a read of
//   byte 0 (released as text when not AA), of byte 1 (byte 0 released when
//   byte 1 is not 55) and of the length (byte 0 released when oversized),
//   then a sum over the frame bytes; the scan closes with an empty check or
//   a look at a partial frame, then a flush
// a stalled receiver holds one result in the output register and one in the
//   hold stage, after that the scan waits in place
// reset (rst high, synchronous) empties the window, clears the line length
//   and start_command_code (byte address 0 of the apb port)
// ----------------------------------------------------------------------------
`default_nettype none

module sync_frame_and_text_line_splitter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic             last,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]         start_cmd;
  sfs_pkg::push_t     req;
  sfs_pkg::push_ack_t ack;
  sfs_pkg::txt_t      txt;
  logic [7:0]         txt_ch;
  logic               txt_commit;

  // apb register file: a single byte-wide register, no wait states
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_cmd <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == sfs_pkg::REG_START_CMD) begin
      start_cmd <= pwdata[7:0];
    end
  end

  // reads beyond the register list return zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == sfs_pkg::REG_START_CMD) begin
      prdata = {24'd0, start_cmd};
    end
  end

  // window sequencer and frame checker
  sfs_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .start_cmd  (start_cmd),
    .ack        (ack),
    .req        (req),
    .txt_ch     (txt_ch),
    .txt_commit (txt_commit),
    .txt        (txt)
  );

  // line builder for released bytes
  sfs_text u_text (
    .clk    (clk),
    .rst    (rst),
    .ch     (txt_ch),
    .commit (txt_commit),
    .txt    (txt)
  );

  // result staging, tags the final result of each byte with last
  sfs_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ack       (ack),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .data_byte (data_byte),
    .last      (last)
  );

endmodule

`default_nettype wire

// File: sim/sync_frame_and_text_line_splitter_unit_test.sv
// ----------------------------------------------------------------------------
// sync_frame_and_text_line_splitter_unit_test
// drives received bytes through the splitter and checks every log and trigger
// result against a byte-level model of the window scan and line builder
// ----------------------------------------------------------------------------
`default_nettype none

module sync_frame_and_text_line_splitter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected result as it should leave the block
  typedef struct {
    sfs_pkg::kind_t kind;
    logic [7:0]     data;
    logic           last;
  } splitter_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: models the frame window and the text line, keeps the results
  // still owed by the block in arrival order
  // --------------------------------------------------------------------------
  class splitter_scoreboard;
    logic [7:0]       start_code;
    logic [7:0]       window [sfs_pkg::WINDOW_BYTES];
    int               fill;
    int               line_len;
    int               failures;
    splitter_result_t awaited [$];
    splitter_result_t step_out [$];

    function new();
      start_code = 8'h00;
      fill       = 0;
      line_len   = 0;
      failures   = 0;
    endfunction

    function void set_start_code(logic [7:0] code);
      start_code = code;
    endfunction

    function void push_result(sfs_pkg::kind_t k, logic [7:0] d);
      splitter_result_t r;
      r.kind = k;
      r.data = d;
      r.last = 1'b0;
      step_out.push_back(r);
    endfunction

    function void drop_front(int count);
      if (count >= fill) begin
        fill = 0;
        return;
      end
      for (int i = 0; i < fill - count; i++) window[i] = window[i + count];
      fill -= count;
    endfunction

    // a byte released to the log path
    function void to_text(logic [7:0] ch);
      if (ch == sfs_pkg::CH_LF) begin
        if (line_len > 0) push_result(sfs_pkg::KIND_LINE_END, 8'h00);
        line_len = 0;
      end else if (ch != sfs_pkg::CH_CR) begin
        if (line_len < sfs_pkg::LINE_BYTES - 1) begin
          line_len++;
          push_result(sfs_pkg::KIND_CHAR, ch);
        end else begin
          line_len = 0;
          push_result(sfs_pkg::KIND_OVERFLOW, 8'h00);
        end
      end
    endfunction

    // an accepted request: append, rescan, queue whatever comes out
    function void note_rx_byte(logic [7:0] b);
      bit         to_release;
      bit         waiting;
      int         plen;
      int         total;
      logic [7:0] sum;
      logic [7:0] ch;
      step_out.delete();
      if (fill >= sfs_pkg::WINDOW_BYTES) begin
        ch = window[0];
        drop_front(1);
        to_text(ch);
      end
      window[fill] = b;
      fill++;
      waiting = 1'b0;
      while (fill > 0 && !waiting) begin
        to_release = 1'b0;
        if (window[0] != sfs_pkg::SYNC_A) begin
          to_release = 1'b1;
        end else if (fill > sfs_pkg::IDX_SYNC_B &&
                     window[sfs_pkg::IDX_SYNC_B] != sfs_pkg::SYNC_B) begin
          to_release = 1'b1;
        end else if (fill < sfs_pkg::HEAD_BYTES) begin
          waiting = 1'b1;
        end else begin
          plen  = window[sfs_pkg::IDX_LEN];
          total = sfs_pkg::HEAD_BYTES + plen + 1;
          if (total > sfs_pkg::WINDOW_BYTES) begin
            to_release = 1'b1;
          end else if (fill < total) begin
            waiting = 1'b1;
          end else begin
            sum = 8'h00;
            for (int i = 0; i < total - 1; i++) sum += window[i];
            if (sum == window[total - 1]) begin
              if (window[sfs_pkg::IDX_CMD] == start_code && plen == 2 &&
                  window[sfs_pkg::IDX_P0] == sfs_pkg::PAY_P0 &&
                  window[sfs_pkg::IDX_P1] == sfs_pkg::PAY_P1) begin
                push_result(sfs_pkg::KIND_TRIGGER, 8'h00);
              end
              drop_front(total);
            end else begin
              to_release = 1'b1;
            end
          end
        end
        if (to_release) begin
          ch = window[0];
          drop_front(1);
          to_text(ch);
        end
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) awaited.push_back(step_out[i]);
    endfunction

    function void match_result(logic [1:0] k, logic [7:0] d, logic l);
      splitter_result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result kind=%0d data_byte=%02h last=%0d", k, d, l);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (k !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, k);
        failures++;
      end
      if (d !== want.data) begin
        $error("data_byte: expected %02h, got %02h", want.data, d);
        failures++;
      end
      if (l !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, l);
        failures++;
      end
    endfunction
  endclass

  // settle time after the last expected result, covers a full window rescan
  localparam int SETTLE_CYCLES = 300;
  // bound on waiting for the owed results to come out
  localparam int DRAIN_LIMIT   = 50000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_stall = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = 3'd0;
  logic [31:0] pwdata    = 32'd0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        last;
  logic [31:0] prdata;
  logic        pready;

  // idle rates in percent of cycles, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  splitter_scoreboard sb;
  // bytes of the sequence being built, sent in order
  logic [7:0] byte_q [$];

  sync_frame_and_text_line_splitter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .data_byte (data_byte),
    .last      (last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  // receiver: random back-pressure, changed only on the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // every result taken by the receiver is checked against the oldest owed one
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.match_result(kind, data_byte, last);
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // apb write of start_command_code: setup phase, then access until pready
  task automatic write_start_code(input logic [7:0] code);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sfs_pkg::REG_START_CMD, 2'b00};
    pwdata  <= {24'($urandom), code};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_start_code(code);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one request; called and returns on a falling edge
  task automatic send_rx_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_rx_byte(b);
    @(negedge clk);
  endtask

  task automatic send_byte_q();
    foreach (byte_q[i]) send_rx_byte(byte_q[i]);
    byte_q.delete();
  endtask

  // sender is held off by the caller; wait for every owed result, then let
  // the scan finish on bytes that owe nothing
  task automatic wait_until_quiet();
    int n;
    n = 0;
    while (sb.awaited.size() > 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (sb.awaited.size() > 0) begin
      $error("results still owed after %0d cycles: %0d", n, sb.awaited.size());
      sb.failures++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // sequence builders
  // --------------------------------------------------------------------------

  // full frame; trig_payload forces 00 FF, sum_flip != 0 breaks the checksum
  task automatic add_frame(input logic [7:0] cmd, input int len, input bit trig_payload,
                           input logic [7:0] sum_flip);
    logic [7:0] sum;
    logic [7:0] p;
    byte_q.push_back(sfs_pkg::SYNC_A);
    byte_q.push_back(sfs_pkg::SYNC_B);
    byte_q.push_back(cmd);
    byte_q.push_back(8'(len));
    sum = sfs_pkg::SYNC_A + sfs_pkg::SYNC_B + cmd + 8'(len);
    for (int i = 0; i < len; i++) begin
      if (trig_payload) p = (i == 0) ? sfs_pkg::PAY_P0 : sfs_pkg::PAY_P1;
      else              p = 8'($urandom);
      byte_q.push_back(p);
      sum += p;
    end
    byte_q.push_back(sum ^ sum_flip);
  endtask

  // printable run; ending 0 none, 1 lf, 2 cr lf
  task automatic add_text(input int n, input int ending);
    for (int i = 0; i < n; i++) byte_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    if (ending == 2) byte_q.push_back(sfs_pkg::CH_CR);
    if (ending >= 1) byte_q.push_back(sfs_pkg::CH_LF);
  endtask

  // mostly small payloads, now and then up to a frame that fills the window
  function automatic int pick_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(7, sfs_pkg::WINDOW_BYTES - 5);
    return $urandom_range(0, 6);
  endfunction

  // --------------------------------------------------------------------------
  // random phase: well-formed frames and text lines with random content,
  // plus broken frames and noise
  // --------------------------------------------------------------------------
  task automatic run_random_phase(input int budget, input bit long_line,
                                  input bit pause_once);
    int         sent;
    int         pick;
    int         len;
    bit         long_done;
    bit         pause_done;
    logic [7:0] flip;
    sent       = 0;
    long_done  = 1'b0;
    pause_done = 1'b0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      flip = 8'($urandom_range(1, 255));
      if (long_line && !long_done && sent >= 40) begin
        // longer than a line can hold: forces the overflow cut
        add_text(sfs_pkg::LINE_BYTES + 2, 0);
        long_done = 1'b1;
      end else if (pick < 25) begin
        // plain valid frame, silent unless command, length and payload happen to match
        add_frame(8'($urandom), pick_len(), 1'b0, 8'h00);
      end else if (pick < 35) begin
        // start command, occasionally with a bad checksum
        add_frame(sb.start_code, 2, 1'b1, ($urandom_range(0, 3) == 0) ? flip : 8'h00);
      end else if (pick < 45) begin
        // near misses of the start command
        case ($urandom_range(0, 2))
          0: add_frame(sb.start_code, 2, 1'b0, 8'h00);
          1: add_frame(sb.start_code ^ flip, 2, 1'b1, 8'h00);
          default: add_frame(sb.start_code, $urandom_range(3, 6), 1'b0, 8'h00);
        endcase
      end else if (pick < 55) begin
        // checksum failure
        add_frame(8'($urandom), pick_len(), 1'b0, flip);
      end else if (pick < 60) begin
        // frame too long for the window
        byte_q.push_back(sfs_pkg::SYNC_A);
        byte_q.push_back(sfs_pkg::SYNC_B);
        byte_q.push_back(8'($urandom));
        byte_q.push_back(8'($urandom_range(sfs_pkg::WINDOW_BYTES - 4, 255)));
        repeat ($urandom_range(0, 3)) byte_q.push_back(8'($urandom));
      end else if (pick < 65) begin
        // header and part of the payload only, later bytes complete it
        len = $urandom_range(1, 10);
        byte_q.push_back(sfs_pkg::SYNC_A);
        byte_q.push_back(sfs_pkg::SYNC_B);
        byte_q.push_back(8'($urandom));
        byte_q.push_back(8'(len));
        repeat ($urandom_range(0, len)) byte_q.push_back(8'($urandom));
      end else if (pick < 85) begin
        // text line, sometimes an empty one
        add_text(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12),
                 $urandom_range(0, 3) == 0 ? 2 : 1);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) byte_q.push_back(8'($urandom));
      end else begin
        // first sync byte followed by anything
        byte_q.push_back(sfs_pkg::SYNC_A);
        byte_q.push_back(8'($urandom));
      end
      sent += byte_q.size();
      send_byte_q();
      if (pause_once && !pause_done && sent >= budget / 2) begin
        // sender holds off until the block has caught up
        in_valid <= 1'b0;
        wait_until_quiet();
        pause_done = 1'b1;
      end
    end
    in_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, command code at its low extreme
    send_idle_pct = 8;
    recv_idle_pct = 65;
    write_start_code(8'h00);
    byte_q.push_back(8'h00);           // lowest byte as a character
    byte_q.push_back(8'hFF);           // highest byte as a character
    byte_q.push_back(sfs_pkg::CH_LF);  // ends a non-empty line
    byte_q.push_back(sfs_pkg::CH_LF);  // empty line, nothing out
    byte_q.push_back(sfs_pkg::CH_CR);  // dropped
    add_frame(8'h00, 2, 1'b1, 8'h00);  // start command, waits for the whole frame
    byte_q.push_back(sfs_pkg::SYNC_A); // broken header: second byte is not 55
    byte_q.push_back(8'h41);
    byte_q.push_back(sfs_pkg::SYNC_A); // length too big for the window
    byte_q.push_back(sfs_pkg::SYNC_B);
    byte_q.push_back(8'h07);
    byte_q.push_back(8'(sfs_pkg::WINDOW_BYTES - 3));
    add_frame(8'h01, 0, 1'b0, 8'h01);  // checksum failure, whole frame rescanned
    byte_q.push_back(sfs_pkg::CH_LF);
    add_frame(8'h03, 0, 1'b0, 8'h00);  // valid frame, silent
    send_byte_q();
    in_valid <= 1'b0;
    wait_until_quiet();

    // code at the high extreme; sender rarely idles, receiver mostly stalls
    write_start_code(8'hFF);
    run_random_phase(170, 1'b1, 1'b0);
    wait_until_quiet();

    // random code; sender mostly idles, receiver rarely stalls
    send_idle_pct = 65;
    recv_idle_pct = 8;
    write_start_code(8'($urandom_range(1, 254)));
    run_random_phase(120, 1'b0, 1'b1);
    wait_until_quiet();

    // back to zero, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_start_code(8'h00);
    run_random_phase(120, 1'b0, 1'b0);
    wait_until_quiet();

    if (sb.awaited.size() != 0) begin
      $error("results never delivered: %0d", sb.awaited.size());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
